// ===== rtl/mtce_pkg.sv =====
// package for the midi track chunk encoder
// transaction structs, function and kind codes, variable-length quantity helpers
// no dependencies
`default_nettype none

package mtce_pkg;

   localparam int MaxEventBytes = 65535;
   localparam int DescBytes     = 9;
   localparam int DescCountW    = $clog2(DescBytes + 1);
   localparam int QueueDepth    = 4;
   localparam int QueuePtrW     = $clog2(QueueDepth);
   localparam int QueueCountW   = $clog2(QueueDepth + 1);

   localparam logic [1:0] FuncHeader = 2'd0;
   localparam logic [1:0] FuncData   = 2'd1;
   localparam logic [1:0] FuncFinish = 2'd2;

   localparam logic CsrRunningStatus = 1'b0;
   localparam logic CsrNoteOffRecast = 1'b1;

   localparam logic [7:0]  ByteMeta     = 8'hFF;
   localparam logic [7:0]  ByteSysex    = 8'hF0;
   localparam logic [7:0]  ByteZero     = 8'h00;
   localparam logic [7:0]  MetaEnd      = 8'h2F;
   localparam logic [3:0]  NoteOffNib   = 4'h8;
   localparam logic [3:0]  NoteOnNib    = 4'h9;
   localparam logic [27:0] DeltaMax     = 28'h0FFFFFFF;

   typedef enum logic [1:0] {
      KindNone,
      KindPass,
      KindRecast
   } kind_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] tick;
      logic [7:0]  status;
      logic [15:0] size;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_flag;
   } rsp_type;

   typedef struct packed {
      logic [DescBytes-1:0][7:0] bytes;
      logic [DescCountW-1:0]     count;
   } desc_type;

   // number of 7-bit groups of a quantity
   function automatic logic [2:0] vlq_len(logic [27:0] v);
      logic [2:0] len;
      if (v[27:21] != 7'd0) begin
         len = 3'd4;
      end else if (v[20:14] != 7'd0) begin
         len = 3'd3;
      end else if (v[13:7] != 7'd0) begin
         len = 3'd2;
      end else begin
         len = 3'd1;
      end
      return len;
   endfunction

   // group g of a quantity, continuation bit on all but group zero
   function automatic logic [7:0] vlq_byte(logic [27:0] v, logic [1:0] g);
      logic [6:0] grp;
      case (g)
         2'd0: grp = v[6:0];
         2'd1: grp = v[13:7];
         2'd2: grp = v[20:14];
         default: grp = v[27:21];
      endcase
      return {(g != 2'd0), grp};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mtce_front.sv =====
// front end: accepts transactions, keeps track state, builds byte descriptors
// depends on mtce_pkg
`default_nettype none

module mtce_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic              q_full,
   input  wire mtce_pkg::req_type req_data,
   input  wire logic              csr_wen,
   input  wire logic              csr_index,
   input  wire logic              csr_wdata,
   output mtce_pkg::desc_type     desc,
   output logic                   desc_push
);
   import mtce_pkg::*;

   logic [31:0] prev_tick_ff, prev_tick_in;
   logic [7:0]  prev_status_ff, prev_status_in;
   kind_type    kind_ff, kind_in;
   logic [15:0] index_ff, index_in;
   logic [15:0] size_ff, size_in;
   logic        ended_ff, ended_in;
   logic        running_ff, recast_cfg_ff;

   logic        accept;
   logic [31:0] delta;
   logic [27:0] delta_sat;
   logic [2:0]  delta_len;
   logic [2:0]  size_len;
   logic [15:0] size_clip;
   logic        recast;
   logic [7:0]  eff_status;
   logic [DescBytes-1:0][7:0] bytes;
   logic [DescCountW-1:0]     n;

   assign accept    = push && !q_full;
   assign delta     = req_data.tick - prev_tick_ff;
   assign delta_sat = (delta[31:28] != 4'd0) ? DeltaMax : delta[27:0];
   assign delta_len = vlq_len(delta_sat);
   assign size_clip = (32'(req_data.size) > 32'(MaxEventBytes)) ?
                      16'(MaxEventBytes) : req_data.size;
   assign size_len  = vlq_len({12'd0, size_clip});
   assign recast    = (req_data.status[7:4] == NoteOffNib) && recast_cfg_ff;
   assign eff_status = recast ? {NoteOnNib, req_data.status[3:0]} : req_data.status;

   always_comb begin
      bytes          = '0;
      n              = '0;
      prev_tick_in   = prev_tick_ff;
      prev_status_in = prev_status_ff;
      kind_in        = kind_ff;
      index_in       = index_ff;
      size_in        = size_ff;
      ended_in       = ended_ff;
      case (req_data.func)
         FuncHeader: begin
            for (int g = 3; g >= 0; g--) begin
               if (g < int'(delta_len)) begin
                  bytes[n] = vlq_byte(delta_sat, 2'(g));
                  n = n + 1'b1;
               end
            end
            prev_tick_in   = req_data.tick;
            size_in        = size_clip;
            index_in       = '0;
            kind_in        = KindNone;
            ended_in       = 1'b0;
            prev_status_in = eff_status;
            if (!req_data.status[7]) begin
               bytes[n] = ByteMeta;
               n = n + 1'b1;
               bytes[n] = req_data.status;
               n = n + 1'b1;
               for (int g = 2; g >= 0; g--) begin
                  if (g < int'(size_len)) begin
                     bytes[n] = vlq_byte({12'd0, size_clip}, 2'(g));
                     n = n + 1'b1;
                  end
               end
               kind_in  = KindPass;
               ended_in = (req_data.status == MetaEnd);
            end else if (req_data.status < ByteSysex) begin
               if (!running_ff || prev_status_ff != eff_status) begin
                  bytes[n] = eff_status;
                  n = n + 1'b1;
               end
               if (recast) begin
                  if (size_clip == 16'd0) begin
                     bytes[n] = ByteZero;
                     n = n + 1'b1;
                     bytes[n] = ByteZero;
                     n = n + 1'b1;
                  end else begin
                     kind_in = KindRecast;
                  end
               end else begin
                  kind_in = KindPass;
               end
            end else if (req_data.status == ByteSysex) begin
               bytes[n] = ByteSysex;
               n = n + 1'b1;
               for (int g = 2; g >= 0; g--) begin
                  if (g < int'(size_len)) begin
                     bytes[n] = vlq_byte({12'd0, size_clip}, 2'(g));
                     n = n + 1'b1;
                  end
               end
               kind_in = KindPass;
            end
         end
         FuncData: begin
            if (kind_ff != KindNone && index_ff < size_ff) begin
               if (kind_ff == KindRecast) begin
                  if (index_ff == 16'd0) begin
                     bytes[0] = req_data.data_byte;
                     bytes[1] = ByteZero;
                     n = DescCountW'(2);
                  end
               end else begin
                  bytes[0] = req_data.data_byte;
                  n = DescCountW'(1);
               end
               index_in = index_ff + 16'd1;
            end
         end
         FuncFinish: begin
            if (!ended_ff) begin
               bytes[0] = ByteZero;
               bytes[1] = ByteMeta;
               bytes[2] = MetaEnd;
               bytes[3] = ByteZero;
               n = DescCountW'(4);
            end
            prev_tick_in   = '0;
            prev_status_in = '0;
            kind_in        = KindNone;
            index_in       = '0;
            size_in        = '0;
            ended_in       = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign desc.bytes = bytes;
   assign desc.count = n;
   assign desc_push  = accept && (n != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_tick_ff   <= '0;
         prev_status_ff <= '0;
         kind_ff        <= KindNone;
         index_ff       <= '0;
         size_ff        <= '0;
         ended_ff       <= 1'b0;
      end else if (accept) begin
         prev_tick_ff   <= prev_tick_in;
         prev_status_ff <= prev_status_in;
         kind_ff        <= kind_in;
         index_ff       <= index_in;
         size_ff        <= size_in;
         ended_ff       <= ended_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         recast_cfg_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            CsrRunningStatus: running_ff    <= csr_wdata;
            CsrNoteOffRecast: recast_cfg_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_desc_count: assert property (@(posedge clock) disable iff (reset)
      desc_push |-> (desc.count <= DescCountW'(DescBytes)))
      else $error("descriptor byte count out of range");
   a_recast_index: assert property (@(posedge clock) disable iff (reset)
      (kind_ff == KindRecast) |-> (size_ff != 16'd0))
      else $error("recast event with no data bytes");
`endif

endmodule

`default_nettype wire

// ===== rtl/mtce_queue.sv =====
// short descriptor queue between front and back
// depends on mtce_pkg
`default_nettype none

module mtce_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire mtce_pkg::desc_type wr_desc,
   input  wire logic               rd_en,
   output mtce_pkg::desc_type      rd_desc,
   output logic                    q_full,
   output logic                    q_empty
);
   import mtce_pkg::*;

   desc_type               entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueCountW-1:0] count_ff, count_in;

   assign q_full  = (count_ff == QueueCountW'(QueueDepth));
   assign q_empty = (count_ff == '0);
   assign rd_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !wr_en)
      else $error("write into full descriptor queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> !rd_en)
      else $error("read from empty descriptor queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/mtce_back.sv =====
// back end: walks descriptor bytes into the result output register
// depends on mtce_pkg
`default_nettype none

module mtce_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire mtce_pkg::desc_type head,
   output logic                    q_pop,
   output logic                    empty,
   input  wire logic               pop,
   output mtce_pkg::rsp_type       rsp_data
);
   import mtce_pkg::*;

   logic [DescCountW-1:0] ptr_ff;
   logic                  valid_ff;
   rsp_type               out_ff;
   logic                  load;
   logic                  at_last;

   assign load    = !q_empty && (!valid_ff || pop);
   assign at_last = (ptr_ff == head.count - 1'b1);
   assign q_pop   = load && at_last;
   assign empty   = !valid_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff.out_byte  <= head.bytes[ptr_ff];
         out_ff.last_flag <= at_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            ptr_ff   <= at_last ? '0 : ptr_ff + 1'b1;
            valid_ff <= 1'b1;
         end else if (pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

`ifndef ASSERT_OFF
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (ptr_ff < head.count))
      else $error("byte pointer past descriptor end");
`endif

endmodule

`default_nettype wire

// ===== rtl/midi_track_chunk_encoder_unit.sv =====
// a taken transaction's descriptor is queued, then its bytes go to the output register
// throughput: one transaction per cycle enters while the four-entry descriptor queue has room
// the back end emits one byte per cycle while its output is popped; a transaction yields
// up to two bytes for data, nine for a header; the byte serializer sets the sustained rate
// reset: synchronous, active high, clears track state, settings, queue and output valid flag
// depends on mtce_pkg, mtce_front, mtce_queue, mtce_back
`default_nettype none

module midi_track_chunk_encoder_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire mtce_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output mtce_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wen,
   input  wire logic              csr_index,
   input  wire logic              csr_wdata
);
   import mtce_pkg::*;

   desc_type new_desc, head_desc;
   logic     desc_push, q_pop, q_full, q_empty;

   assign full = q_full;

   mtce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .q_full    (q_full),
      .req_data  (req_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .desc      (new_desc),
      .desc_push (desc_push)
   );

   mtce_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (desc_push),
      .wr_desc (new_desc),
      .rd_en   (q_pop),
      .rd_desc (head_desc),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   mtce_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .head     (head_desc),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
